FILE: hdl/dbt_pkg.sv
package dbt_pkg;

  localparam int DEF_MAX_ROWS    = 512;
  localparam int DEF_MAX_COLUMNS = 512;

  localparam int COORD_W    = 12;
  localparam int LIMIT_W    = 10;
  localparam int DEPTH_BITS = 24;
  localparam int TAG_BITS   = 20;
  localparam int LINEAR_W   = 2 * COORD_W;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [0:0] REG_ROWS    = 1'b0;
  localparam logic [0:0] REG_COLUMNS = 1'b1;

  localparam logic [LIMIT_W-1:0] ROWS_RESET    = 10'd512;
  localparam logic [LIMIT_W-1:0] COLUMNS_RESET = 10'd512;

  localparam logic ACT_TEST = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] STATUS_PASS     = 2'd0;
  localparam logic [1:0] STATUS_FAIL     = 2'd1;
  localparam logic [1:0] STATUS_OFF_GRID = 2'd2;
  localparam logic [1:0] STATUS_READ     = 2'd3;

  localparam logic [DEPTH_BITS-1:0] DEPTH_FAR = '1;

  typedef struct packed {
    logic                    action;
    logic signed [COORD_W-1:0] pixel_row;
    logic signed [COORD_W-1:0] pixel_column;
    logic [DEPTH_BITS-1:0]   fragment_depth;
    logic [TAG_BITS-1:0]     fragment_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  entry_occupied;
    logic [TAG_BITS-1:0]   entry_tag;
    logic [DEPTH_BITS-1:0] entry_depth;
  } rsp_t;

  typedef struct packed {
    logic                  occupied;
    logic [TAG_BITS-1:0]   tag;
    logic [DEPTH_BITS-1:0] depth;
  } entry_t;

  localparam entry_t ENTRY_CLEAR = '{occupied: 1'b0, tag: '0, depth: DEPTH_FAR};

endpackage

FILE: hdl/dbt_pixel_store.sv
module dbt_pixel_store import dbt_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_ROWS * DEF_MAX_COLUMNS,
  parameter int ADDR_W = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output entry_t            rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  entry_t            wr_data_i,
  output logic              busy_o
);

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  logic              busy_q, busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  logic              we;
  logic [ADDR_W-1:0] wa;
  entry_t            wd;

  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we = busy_q || wr_en_i;
  assign wa = busy_q ? clr_addr_q : wr_addr_i;
  assign wd = busy_q ? ENTRY_CLEAR : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

FILE: hdl/depth_buffer_test.sv
// Per-pixel depth buffer with depth test and read-and-clear.
// Request channel: req_i with in_valid_i / in_stall_o. A request either
// depth-tests a fragment at (pixel_row, pixel_column) or reads one pixel and
// clears it for the next frame. Response channel: rsp_o with out_valid_o /
// out_stall_i, one response per request, in request order.
// Grid size is set through the APB port: rows_in_use at 0x0, columns_in_use
// at 0x4; write these only while no request is in flight.
// Throughput: one request per cycle while in_stall_o is low. Pipeline: each
// request is registered in stage s1 with its store read, then its response in
// the output register rsp_q. The entry store is a single-port write,
// single-port read memory with a registered read; a write from the request
// just ahead is forwarded to the one behind it.
// Reset: the grid registers return to 512 x 512 and the store is swept one
// entry per cycle to far depth, tag zero, not occupied. The sweep covers all
// MAX_ROWS * MAX_COLUMNS entries (262144 by default); in_stall_o is high
// throughout. Configuration writes are taken during the sweep.
// Stall: while out_stall_i holds a pending response, the whole pipe holds
// and in_stall_o rises; nothing is dropped or repeated.
module depth_buffer_test import dbt_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  req_t               req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsp_t               rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int StoreSize = MAX_ROWS * MAX_COLUMNS;
  localparam int AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;

  logic [LIMIT_W-1:0] rows_q, rows_d;
  logic [LIMIT_W-1:0] cols_q, cols_d;
  logic [0:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    prdata = '0;
    unique case (reg_idx)
      REG_ROWS: begin
        prdata = PDATA_W'(rows_q);
        if (cfg_wr) begin
          rows_d = pwdata[LIMIT_W-1:0];
        end
      end
      REG_COLUMNS: begin
        prdata = PDATA_W'(cols_q);
        if (cfg_wr) begin
          cols_d = pwdata[LIMIT_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLUMNS_RESET;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  logic               clearing;
  logic               advance;
  logic               in_accept;
  logic [COORD_W-1:0] row_limit;
  logic [COORD_W-1:0] col_limit;
  logic               row_ok;
  logic               col_ok;
  logic [LINEAR_W-1:0] linear;
  logic [AddrW-1:0]   s0_addr;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = clearing || !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign row_limit = (COORD_W'(rows_q) < COORD_W'(MAX_ROWS)) ?
                     COORD_W'(rows_q) : COORD_W'(MAX_ROWS);
  assign col_limit = (COORD_W'(cols_q) < COORD_W'(MAX_COLUMNS)) ?
                     COORD_W'(cols_q) : COORD_W'(MAX_COLUMNS);

  assign row_ok = !req_i.pixel_row[COORD_W-1] &&
                  ({1'b0, req_i.pixel_row[COORD_W-2:0]} < row_limit);
  assign col_ok = !req_i.pixel_column[COORD_W-1] &&
                  ({1'b0, req_i.pixel_column[COORD_W-2:0]} < col_limit);

  assign linear  = LINEAR_W'(req_i.pixel_row[COORD_W-2:0]) * LINEAR_W'(MAX_COLUMNS) +
                   LINEAR_W'(req_i.pixel_column[COORD_W-2:0]);
  assign s0_addr = linear[AddrW-1:0];

  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_on_grid_q;
  logic                  s1_action_q;
  logic [AddrW-1:0]      s1_addr_q;
  logic [DEPTH_BITS-1:0] s1_depth_q;
  logic [TAG_BITS-1:0]   s1_tag_q;

  assign s1_valid_d = advance ? in_accept : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_on_grid_q <= row_ok && col_ok;
      s1_action_q  <= req_i.action;
      s1_addr_q    <= s0_addr;
      s1_depth_q   <= req_i.fragment_depth;
      s1_tag_q     <= req_i.fragment_tag;
    end
  end

  entry_t           rd_data;
  entry_t           cur;
  entry_t           new_entry;
  logic             upd;
  logic             mem_we;
  logic             fwd_hit;
  logic             wr_valid_q;
  logic [AddrW-1:0] wr_addr_q;
  entry_t           wr_data_q;
  rsp_t             rsp_d;
  rsp_t             rsp_q;
  logic             out_valid_q;

  dbt_pixel_store #(
    .DEPTH  (StoreSize),
    .ADDR_W (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (s0_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_we),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (new_entry),
    .busy_o    (clearing)
  );

  assign fwd_hit = wr_valid_q && (wr_addr_q == s1_addr_q);
  assign cur     = fwd_hit ? wr_data_q : rd_data;

  always_comb begin
    rsp_d     = '0;
    new_entry = cur;
    upd       = 1'b0;
    if (!s1_on_grid_q) begin
      rsp_d.status = STATUS_OFF_GRID;
    end else begin
      case (s1_action_q)
        ACT_TEST: begin
          if (s1_depth_q <= cur.depth) begin
            rsp_d.status       = STATUS_PASS;
            new_entry.occupied = 1'b1;
            new_entry.tag      = s1_tag_q;
            new_entry.depth    = s1_depth_q;
            upd                = 1'b1;
          end else begin
            rsp_d.status = STATUS_FAIL;
          end
        end
        default: begin
          rsp_d.status         = STATUS_READ;
          rsp_d.entry_occupied = cur.occupied;
          rsp_d.entry_tag      = cur.tag;
          rsp_d.entry_depth    = cur.depth;
          new_entry            = ENTRY_CLEAR;
          upd                  = 1'b1;
        end
      endcase
    end
  end

  assign mem_we = s1_valid_q && advance && upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      wr_valid_q  <= mem_we;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= new_entry;
      rsp_q     <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  a_sweep_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s1_valid_q && !out_valid_q)
    else $error("request in flight during store sweep");

  a_s1_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !$past(s1_valid_q) |-> $past(in_valid_i && !in_stall_o))
    else $error("pipe stage filled without an accepted request");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> s1_valid_q && s1_on_grid_q && !clearing)
    else $error("store written without an on-grid request");

  a_pass_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $rose(out_valid_o) && rsp_o.status == STATUS_PASS |->
      $past(mem_we))
    else $error("passing fragment not written to the store");

endmodule

FILE: tb/tb_depth_buffer_test.sv
module tb_depth_buffer_test;
  import dbt_pkg::*;

  localparam int          CLK_PERIOD   = 12;
  localparam int unsigned LIMIT_CYCLES = 1_200_000;
  localparam int          MAX_ROWS     = DEF_MAX_ROWS;
  localparam int          MAX_COLUMNS  = DEF_MAX_COLUMNS;
  localparam int          LONG_HOLD    = 90;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  req_t               req_i       = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rsp_t               rsp_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  depth_buffer_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_i       (req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rsp_o       (rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  req_t        pending_req [$];
  rsp_t        expected_rsp [$];
  entry_t      pixel_copy [int];
  int          row_lim      = MAX_ROWS;
  int          col_lim      = MAX_COLUMNS;
  int          send_max     = 0;
  int          stall_max    = 0;
  int          send_gap     = 0;
  int          stall_left   = 0;
  int          hold_asked   = 0;
  int          hold_served  = 0;
  int unsigned issued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fault_cnt    = 0;
  logic        req_taken    = 1'b0;
  logic        rsp_taken    = 1'b0;

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  function automatic rsp_t resolve_fragment(req_t r);
    rsp_t   res;
    entry_t slot;
    int     row;
    int     col;
    int     key;
    res = '0;
    row = $signed(r.pixel_row);
    col = $signed(r.pixel_column);
    if (row < 0 || col < 0 || row >= row_lim || col >= col_lim) begin
      res.status = STATUS_OFF_GRID;
      return res;
    end
    key  = row * MAX_COLUMNS + col;
    slot = pixel_copy.exists(key) ? pixel_copy[key] : ENTRY_CLEAR;
    if (r.action == ACT_TEST) begin
      if (r.fragment_depth <= slot.depth) begin
        slot.occupied   = 1'b1;
        slot.tag        = r.fragment_tag;
        slot.depth      = r.fragment_depth;
        pixel_copy[key] = slot;
        res.status      = STATUS_PASS;
      end else begin
        res.status = STATUS_FAIL;
      end
    end else begin
      res.status         = STATUS_READ;
      res.entry_occupied = slot.occupied;
      res.entry_tag      = slot.tag;
      res.entry_depth    = slot.depth;
      pixel_copy.delete(key);
    end
    return res;
  endfunction

  task automatic flag_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
      fault_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    rsp_t want;
    req_taken <= in_valid_i && !in_stall_o;
    rsp_taken <= out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: response expected none actual %p", $time, rsp_o);
          fault_cnt++;
        end else begin
          want = expected_rsp.pop_front();
          flag_field("status", 32'(want.status), 32'(rsp_o.status));
          flag_field("entry_occupied", 32'(want.entry_occupied), 32'(rsp_o.entry_occupied));
          flag_field("entry_tag", 32'(want.entry_tag), 32'(rsp_o.entry_tag));
          flag_field("entry_depth", 32'(want.entry_depth), 32'(rsp_o.entry_depth));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_rsp = {expected_rsp, resolve_fragment(req_i)};
        accepted_cnt++;
      end
    end
  end

  always @(negedge clk_i) begin : req_drive
    if (rst_ni && !(in_valid_i && !req_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_req.size() != 0) begin
        req_i      <= pending_req.pop_front();
        in_valid_i <= 1'b1;
        issued_cnt++;
        send_gap = $urandom_range(0, send_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : rsp_stall
    if (rsp_taken) stall_left = $urandom_range(0, stall_max);
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      stall_left  = LONG_HOLD;
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  task automatic wait_quiet();
    while (pending_req.size() != 0 || accepted_cnt != issued_cnt ||
           expected_rsp.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_limit(logic [0:0] sel, logic [LIMIT_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {22'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    flag_field(sel == REG_ROWS ? "rows_in_use" : "columns_in_use", 32'(value), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_ROWS) row_lim = (int'(value) < MAX_ROWS) ? int'(value) : MAX_ROWS;
    else col_lim = (int'(value) < MAX_COLUMNS) ? int'(value) : MAX_COLUMNS;
  endtask

  task automatic queue_req(logic act, int row, int col, int depth, int tag);
    req_t r;
    r.action         = act;
    r.pixel_row      = row[COORD_W-1:0];
    r.pixel_column   = col[COORD_W-1:0];
    r.fragment_depth = depth[DEPTH_BITS-1:0];
    r.fragment_tag   = tag[TAG_BITS-1:0];
    pending_req = {pending_req, r};
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(int lim);
    int k;
    case ($urandom_range(0, 9))
      0: k = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       k = -1;
          1:       k = lim - 1;
          2:       k = lim;
          default: k = 0;
        endcase
      end
      default: begin
        k = $urandom_range(0, (lim > 6) ? 5 : ((lim > 0) ? lim - 1 : 0));
        if ($urandom_range(0, 1) && lim > 0) k = lim - 1 - k;
      end
    endcase
    return k[COORD_W-1:0];
  endfunction

  function automatic logic [DEPTH_BITS-1:0] pick_depth();
    case ($urandom_range(0, 7))
      0:       return DEPTH_FAR;
      1:       return '0;
      2, 3:    return DEPTH_BITS'($urandom);
      default: return DEPTH_BITS'(1000 + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic run_phase(int rows, int cols, int smax, int stmax, int count,
                           bit long_hold);
    req_t r;
    program_limit(REG_ROWS, rows[LIMIT_W-1:0]);
    program_limit(REG_COLUMNS, cols[LIMIT_W-1:0]);
    send_max  = smax;
    stall_max = stmax;
    repeat (count) begin
      r.action         = ($urandom_range(0, 9) < 3) ? ACT_READ : ACT_TEST;
      r.pixel_row      = pick_coord(row_lim);
      r.pixel_column   = pick_coord(col_lim);
      r.fragment_depth = pick_depth();
      r.fragment_tag   = TAG_BITS'($urandom);
      pending_req = {pending_req, r};
    end
    if (long_hold) hold_asked++;
    wait_quiet();
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_req(ACT_READ, 0, 0, 0, 0);
    queue_req(ACT_TEST, 0, 0, 24'hFFFFFF, 20'h11111);
    queue_req(ACT_TEST, 0, 0, 24'hFFFFFF, 20'h22222);
    queue_req(ACT_TEST, 0, 0, 100, 20'h33333);
    queue_req(ACT_TEST, 0, 0, 101, 20'h44444);
    queue_req(ACT_TEST, 0, 0, 100, 20'h55555);
    queue_req(ACT_READ, 0, 0, 0, 0);
    queue_req(ACT_READ, 0, 0, 0, 0);
    queue_req(ACT_TEST, 511, 511, 0, 20'hFFFFF);
    queue_req(ACT_TEST, 511, 511, 0, 0);
    queue_req(ACT_READ, 511, 511, 24'hFFFFFF, 20'hFFFFF);
    queue_req(ACT_TEST, -1, 0, 5, 1);
    queue_req(ACT_TEST, 0, -1, 5, 1);
    queue_req(ACT_TEST, 512, 3, 5, 1);
    queue_req(ACT_TEST, 3, 512, 5, 1);
    queue_req(ACT_TEST, -2048, 2047, 0, 1);
    queue_req(ACT_READ, 2047, -2048, 0, 0);
    queue_req(ACT_READ, 512, 0, 0, 0);
    queue_req(ACT_TEST, 5, 7, 500, 1);
    queue_req(ACT_TEST, 5, 7, 400, 2);
    queue_req(ACT_TEST, 5, 7, 450, 3);
    queue_req(ACT_READ, 5, 7, 0, 0);
    queue_req(ACT_TEST, 0, 511, 24'hFFFFFE, 20'hABCDE);
    queue_req(ACT_READ, 0, 511, 0, 0);
    wait_quiet();

    run_phase(512, 512, 9, 9, 185, 1'b0);
    run_phase(1, 1, 9, 9, 185, 1'b0);
    run_phase(8, 5, 0, 0, 185, 1'b0);
    run_phase(0, 512, 9, 9, 40, 1'b0);
    run_phase(512, 0, 9, 9, 40, 1'b0);
    run_phase(1023, 1023, 0, 3, 185, 1'b1);
    run_phase(37, 600, 9, 9, 185, 1'b0);
    run_phase(512, 1, 3, 9, 185, 1'b0);
    run_phase(2, 512, 9, 0, 185, 1'b0);
    run_phase(16, 16, 9, 9, 185, 1'b0);
    run_phase(512, 512, 9, 9, 185, 1'b0);

    repeat (8) @(negedge clk_i);
    if (fault_cnt == 0) begin
      $display("depth_buffer_test verification clean");
    end else begin
      $display("depth_buffer_test verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("depth_buffer_test verification failed");
    $finish;
  end

endmodule
